FILE: rtl/baro_pkg.sv
`default_nettype none

package baro_pkg;

   localparam int RAW_W     = 24;
   localparam int COEF_W    = 16;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int NUM_REGS  = 6;
   localparam int INDEX_W   = ADDR_W - 2;

   localparam int DT_W      = RAW_W + 1;
   localparam int PROD_W    = DT_W + COEF_W + 1;
   localparam int SQ_W      = 2 * DT_W;
   localparam int TEMP_W    = 20;
   localparam int TOUT_W    = 19;
   localparam int PRES_W    = 32;
   localparam int SQR_W     = 36;
   localparam int OFF1_W    = 44;
   localparam int OFF2P_W   = 44;
   localparam int OFF_W     = OFF2P_W + 2;
   localparam int SENS_W    = 44;

   localparam int TEMP_SH   = 23;
   localparam int T2C_SH    = 33;
   localparam int T2W_SH    = 38;
   localparam int T2_W      = SQ_W + 1 - T2C_SH;
   localparam int OFF_SH    = 7;
   localparam int SENS_SH   = 8;
   localparam int OFF_REF_SH  = 16;
   localparam int SENS_REF_SH = 15;
   localparam int REF_T_SH  = 8;
   localparam int DIV16_SH  = 4;
   localparam int SPLIT_W   = 21;
   localparam int P_SH      = 15;
   localparam int PLO_W     = RAW_W + SPLIT_W;
   localparam int PHI_W     = RAW_W + 1 + SENS_W - SPLIT_W;
   localparam int SUM_W     = PHI_W + 2;

   localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
   localparam logic signed [TEMP_W-1:0] TEMP_VLOW = TEMP_W'(-1500);

   localparam logic [7:0] K_OFF_LO  = 8'd61;
   localparam logic [7:0] K_SENS_LO = 8'd29;
   localparam logic [7:0] K_OFF_VLO = 8'd17;
   localparam logic [7:0] K_SENS_VLO = 8'd9;

   localparam logic [INDEX_W-1:0] REG_SENS_AT_REF       = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_OFFSET_AT_REF     = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] REG_SENS_TEMP_COEFF   = INDEX_W'(2);
   localparam logic [INDEX_W-1:0] REG_OFFSET_TEMP_COEFF = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] REG_REF_TEMPERATURE   = INDEX_W'(4);
   localparam logic [INDEX_W-1:0] REG_TEMP_SENSITIVITY  = INDEX_W'(5);

   typedef struct packed {
      logic [COEF_W-1:0] sens_at_ref;
      logic [COEF_W-1:0] offset_at_ref;
      logic [COEF_W-1:0] sens_temp_coeff;
      logic [COEF_W-1:0] offset_temp_coeff;
      logic [COEF_W-1:0] ref_temperature;
      logic [COEF_W-1:0] temp_sensitivity;
   } baro_coef_type;

   typedef struct packed {
      logic                     valid;
      logic                     low;
      logic                     vlow;
      logic [SQR_W-1:0]         lo_sq;
      logic [SQR_W-1:0]         vlo_sq;
      logic signed [TEMP_W-1:0] tout;
      logic signed [OFF1_W-1:0] off1;
      logic signed [OFF1_W-1:0] sens1;
      logic [RAW_W-1:0]         d1;
   } baro_mid_type;

endpackage

`default_nettype wire

FILE: rtl/baro_csr.sv
`default_nettype none

module baro_csr
   import baro_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output baro_coef_type          coef
);

   baro_coef_type        coef_ff;
   logic                 wr_en;
   logic [INDEX_W-1:0]   index;
   logic [COEF_W-1:0]    rd_val;

   assign index  = paddr[ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign coef   = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (wr_en) begin
         case (index)
            REG_SENS_AT_REF:       coef_ff.sens_at_ref       <= pwdata[COEF_W-1:0];
            REG_OFFSET_AT_REF:     coef_ff.offset_at_ref     <= pwdata[COEF_W-1:0];
            REG_SENS_TEMP_COEFF:   coef_ff.sens_temp_coeff   <= pwdata[COEF_W-1:0];
            REG_OFFSET_TEMP_COEFF: coef_ff.offset_temp_coeff <= pwdata[COEF_W-1:0];
            REG_REF_TEMPERATURE:   coef_ff.ref_temperature   <= pwdata[COEF_W-1:0];
            REG_TEMP_SENSITIVITY:  coef_ff.temp_sensitivity  <= pwdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SENS_AT_REF:       rd_val = coef_ff.sens_at_ref;
         REG_OFFSET_AT_REF:     rd_val = coef_ff.offset_at_ref;
         REG_SENS_TEMP_COEFF:   rd_val = coef_ff.sens_temp_coeff;
         REG_OFFSET_TEMP_COEFF: rd_val = coef_ff.offset_temp_coeff;
         REG_REF_TEMPERATURE:   rd_val = coef_ff.ref_temperature;
         REG_TEMP_SENSITIVITY:  rd_val = coef_ff.temp_sensitivity;
         default:               rd_val = '0;
      endcase
   end

   assign prdata = DATA_W'(rd_val);

endmodule

`default_nettype wire

FILE: rtl/baro_front.sv
`default_nettype none

module baro_front
   import baro_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [RAW_W-1:0] d1,
   input  wire logic [RAW_W-1:0] d2,
   input  wire baro_coef_type    coef,
   output baro_mid_type          mid
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [DT_W-1:0]   dt_in, dt_ff;
   logic [RAW_W-1:0]         d1_s1_ff;

   logic signed [PROD_W-1:0] mt_in, mt_ff;
   logic signed [SQ_W-1:0]   sq_in, sq_ff;
   logic signed [PROD_W-1:0] c4dt_in, c4dt_ff;
   logic signed [PROD_W-1:0] c3dt_in, c3dt_ff;
   logic [RAW_W-1:0]         d1_s2_ff;

   logic [SQ_W-2:0]          sq_u;
   logic [SQ_W:0]            sq3;
   logic [SQ_W+1:0]          sq5;
   logic signed [TEMP_W-1:0] temp_in, temp_ff;
   logic [T2_W-1:0]          t2_in, t2_ff;
   logic                     low_in, low_ff;
   logic                     vlow_in, vlow_ff;
   logic signed [OFF1_W-1:0] off1_in, off1_ff;
   logic signed [OFF1_W-1:0] sens1_in, sens1_ff;
   logic [RAW_W-1:0]         d1_s3_ff;

   logic signed [TEMP_W-1:0]   lo, vlo;
   logic signed [2*TEMP_W-1:0] lo_sq_full, vlo_sq_full;
   logic signed [TEMP_W-1:0]   tout_in;
   logic [SQR_W-1:0]           lo_sq_ff, vlo_sq_ff;
   logic signed [TEMP_W-1:0]   tout_ff;
   logic                       low_s4_ff, vlow_s4_ff;
   logic signed [OFF1_W-1:0]   off1_s4_ff, sens1_s4_ff;
   logic [RAW_W-1:0]           d1_s4_ff;

   assign dt_in = $signed({1'b0, d2}) -
                  $signed({1'b0, coef.ref_temperature, {REF_T_SH{1'b0}}});

   assign mt_in   = dt_ff * $signed({1'b0, coef.temp_sensitivity});
   assign sq_in   = dt_ff * dt_ff;
   assign c4dt_in = dt_ff * $signed({1'b0, coef.offset_temp_coeff});
   assign c3dt_in = dt_ff * $signed({1'b0, coef.sens_temp_coeff});

   assign sq_u     = sq_ff[SQ_W-2:0];
   assign sq3      = {sq_u, 1'b0} + {1'b0, sq_u};
   assign sq5      = {sq_u, 2'b00} + sq_u;
   assign temp_in  = $signed(mt_ff[PROD_W-1:TEMP_SH]) + TEMP_REF;
   assign low_in   = temp_in < TEMP_REF;
   assign vlow_in  = temp_in < TEMP_VLOW;
   assign t2_in    = low_in ? sq3[SQ_W:T2C_SH] : T2_W'(sq5[SQ_W+1:T2W_SH]);
   assign off1_in  = $signed({1'b0, coef.offset_at_ref, {OFF_REF_SH{1'b0}}}) +
                     $signed(c4dt_ff[PROD_W-1:OFF_SH]);
   assign sens1_in = $signed({1'b0, coef.sens_at_ref, {SENS_REF_SH{1'b0}}}) +
                     $signed(c3dt_ff[PROD_W-1:SENS_SH]);

   assign lo          = temp_ff - TEMP_REF;
   assign vlo         = temp_ff - TEMP_VLOW;
   assign lo_sq_full  = lo * lo;
   assign vlo_sq_full = vlo * vlo;
   assign tout_in     = temp_ff - $signed({{(TEMP_W-T2_W){1'b0}}, t2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dt_ff       <= dt_in;
         d1_s1_ff    <= d1;

         mt_ff       <= mt_in;
         sq_ff       <= sq_in;
         c4dt_ff     <= c4dt_in;
         c3dt_ff     <= c3dt_in;
         d1_s2_ff    <= d1_s1_ff;

         temp_ff     <= temp_in;
         t2_ff       <= t2_in;
         low_ff      <= low_in;
         vlow_ff     <= vlow_in;
         off1_ff     <= off1_in;
         sens1_ff    <= sens1_in;
         d1_s3_ff    <= d1_s2_ff;

         lo_sq_ff    <= lo_sq_full[SQR_W-1:0];
         vlo_sq_ff   <= vlo_sq_full[SQR_W-1:0];
         tout_ff     <= tout_in;
         low_s4_ff   <= low_ff;
         vlow_s4_ff  <= vlow_ff;
         off1_s4_ff  <= off1_ff;
         sens1_s4_ff <= sens1_ff;
         d1_s4_ff    <= d1_s3_ff;
      end
   end

   assign mid.valid  = v4_ff;
   assign mid.low    = low_s4_ff;
   assign mid.vlow   = vlow_s4_ff;
   assign mid.lo_sq  = lo_sq_ff;
   assign mid.vlo_sq = vlo_sq_ff;
   assign mid.tout   = tout_ff;
   assign mid.off1   = off1_s4_ff;
   assign mid.sens1  = sens1_s4_ff;
   assign mid.d1     = d1_s4_ff;

endmodule

`default_nettype wire

FILE: rtl/baro_back.sv
`default_nettype none

module baro_back
   import baro_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire baro_mid_type       mid,
   output logic                    out_valid,
   output logic signed [TOUT_W-1:0] temp_centi,
   output logic signed [PRES_W-1:0] pressure
);

   logic v5_ff, v6_ff, v7_ff;

   logic [OFF2P_W-1:0]       lo61, lo29, vlo17, vlo9;
   logic [OFF2P_W-1:0]       off2, sens2;
   logic signed [OFF_W-1:0]  off_in, off_ff, off_s6_ff;
   logic signed [SENS_W-1:0] sens_in, sens_ff;
   logic [RAW_W-1:0]         d1_s5_ff;
   logic signed [TEMP_W-1:0] tout_s5_ff, tout_s6_ff;

   logic [PLO_W-1:0]         plo_in, plo_ff;
   logic signed [PHI_W-1:0]  phi_in, phi_ff;

   logic signed [SUM_W-1:0]  sum;
   logic signed [TOUT_W-1:0] tout_o_ff;
   logic signed [PRES_W-1:0] p_ff;

   assign lo61  = OFF2P_W'(mid.lo_sq)  * K_OFF_LO;
   assign lo29  = OFF2P_W'(mid.lo_sq)  * K_SENS_LO;
   assign vlo17 = OFF2P_W'(mid.vlo_sq) * K_OFF_VLO;
   assign vlo9  = OFF2P_W'(mid.vlo_sq) * K_SENS_VLO;

   always_comb begin
      off2  = '0;
      sens2 = '0;
      if (mid.low) begin
         off2  = (lo61 >> DIV16_SH) + (mid.vlow ? vlo17 : '0);
         sens2 = (lo29 >> DIV16_SH) + (mid.vlow ? vlo9 : '0);
      end
   end

   assign off_in  = mid.off1 - $signed({2'b00, off2});
   assign sens_in = mid.sens1 - $signed({1'b0, sens2[OFF2P_W-2:0]});

   assign plo_in = d1_s5_ff * sens_ff[SPLIT_W-1:0];
   assign phi_in = $signed({1'b0, d1_s5_ff}) * $signed(sens_ff[SENS_W-1:SPLIT_W]);

   assign sum = phi_ff + $signed({1'b0, plo_ff[PLO_W-1:SPLIT_W]}) - off_s6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= mid.valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff     <= off_in;
         sens_ff    <= sens_in;
         d1_s5_ff   <= mid.d1;
         tout_s5_ff <= mid.tout;

         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         off_s6_ff  <= off_ff;
         tout_s6_ff <= tout_s5_ff;

         tout_o_ff  <= tout_s6_ff[TOUT_W-1:0];
         p_ff       <= sum[P_SH+PRES_W-1:P_SH];
      end
   end

   assign out_valid  = v7_ff;
   assign temp_centi = tout_o_ff;
   assign pressure   = p_ff;

endmodule

`default_nettype wire

FILE: rtl/baro_pressure_temp_compensation.sv
`default_nettype none
// Second-order compensated barometric pressure and temperature.
// Request channel: req_valid/req_ready carry one raw pressure and one raw
// temperature conversion. Response channel: rsp_valid/rsp_ready return the
// temperature in hundredths of a degree and the pressure in pascals.
// Six calibration words sit behind the APB port at byte address 4*i; write
// them while no request is in flight.
// Throughput: one request per cycle unless the receiver stalls. rsp_valid
// rises once the accepted request has passed seven register stages (offset
// of the reference temperature, products with the raw temperature difference,
// first-order terms, squares of the low-temperature terms, offset and
// sensitivity, split pressure product, final sum and shift).
// Reset clears all calibration words to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and req_ready drops;
// no request is lost or repeated.

module baro_pressure_temp_compensation
   import baro_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [RAW_W-1:0]     req_pressure_raw,
   input  wire logic [RAW_W-1:0]     req_temperature_raw,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [TOUT_W-1:0]  rsp_temperature_centi,
   output logic signed [PRES_W-1:0]  rsp_pressure_pa,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_W-1:0]    paddr,
   input  wire logic [DATA_W-1:0]    pwdata,
   output logic      [DATA_W-1:0]    prdata,
   output logic                      pready
);

   baro_coef_type coef;
   baro_mid_type  mid;
   logic          en;
   logic          out_valid;

   assign en        = !out_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_valid;

   baro_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   baro_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .d1       (req_pressure_raw),
      .d2       (req_temperature_raw),
      .coef     (coef),
      .mid      (mid)
   );

   baro_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .mid        (mid),
      .out_valid  (out_valid),
      .temp_centi (rsp_temperature_centi),
      .pressure   (rsp_pressure_pa)
   );

endmodule

`default_nettype wire

FILE: test/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_test;
   import baro_pkg::*;

   localparam int PIPE_LATENCY = 7;
   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int REG_UNMAPPED_LO = NUM_REGS;
   localparam int REG_UNMAPPED_HI = NUM_REGS + 1;
   localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
   localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

   typedef struct packed {
      logic signed [TOUT_W-1:0] temperature_centi;
      logic signed [PRES_W-1:0] pressure_pa;
   } reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RAW_W-1:0]         req_pressure_raw = '0;
   logic [RAW_W-1:0]         req_temperature_raw = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [TOUT_W-1:0] rsp_temperature_centi;
   logic signed [PRES_W-1:0] rsp_pressure_pa;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   logic [COEF_W-1:0] cal_word [NUM_REGS];
   reading_type       expected_readings[$];
   int                error_count = 0;
   int                ready_left = 0;
   logic              ready_level = 1'b1;

   baro_pressure_temp_compensation u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_pressure_raw      (req_pressure_raw),
      .req_temperature_raw   (req_temperature_raw),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_pa       (rsp_pressure_pa),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic reading_type predict_reading(input logic [RAW_W-1:0] pressure_raw,
                                                   input logic [RAW_W-1:0] temperature_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, t2, off2, sens2, lo, vlo, off, sens, pres;
      reading_type r;
      d1 = longint'(pressure_raw);
      d2 = longint'(temperature_raw);
      c1 = longint'(cal_word[REG_SENS_AT_REF]);
      c2 = longint'(cal_word[REG_OFFSET_AT_REF]);
      c3 = longint'(cal_word[REG_SENS_TEMP_COEFF]);
      c4 = longint'(cal_word[REG_OFFSET_TEMP_COEFF]);
      c5 = longint'(cal_word[REG_REF_TEMPERATURE]);
      c6 = longint'(cal_word[REG_TEMP_SENSITIVITY]);
      dt = d2 - c5 * 256;
      temp = 2000 + ((dt * c6) >>> 23);
      if (temp < 2000) begin
         lo = temp - 2000;
         t2 = (3 * (dt * dt)) >>> 33;
         off2 = 61 * lo * lo / 16;
         sens2 = 29 * lo * lo / 16;
         if (temp < -1500) begin
            vlo = temp + 1500;
            off2 += 17 * vlo * vlo;
            sens2 += 9 * vlo * vlo;
         end
      end else begin
         t2 = (5 * (dt * dt)) >>> 38;
         off2 = 0;
         sens2 = 0;
      end
      off = c2 * 65536 + ((c4 * dt) >>> 7) - off2;
      sens = c1 * 32768 + ((c3 * dt) >>> 8) - sens2;
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      r.temperature_centi = TOUT_W'(temp - t2);
      r.pressure_pa = PRES_W'(pres);
      return r;
   endfunction

   always @(posedge clock) begin
      if (ready_left <= 0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_level = 1'b0;
               ready_left = $urandom_range(1, 6);
            end
            1: begin
               ready_level = 1'b1;
               ready_left = $urandom_range(40, 150);
            end
            default: begin
               ready_level = 1'b1;
               ready_left = $urandom_range(1, 12);
            end
         endcase
      end
      ready_left--;
      rsp_ready <= ready_level;
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected response temperature_centi %0d pressure_pa %0d",
                     $time, rsp_temperature_centi, rsp_pressure_pa);
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temperature_centi !== want.temperature_centi) begin
               $display("%0t: temperature_centi expected %0d actual %0d",
                        $time, want.temperature_centi, rsp_temperature_centi);
               error_count++;
            end
            if (rsp_pressure_pa !== want.pressure_pa) begin
               $display("%0t: pressure_pa expected %0d actual %0d",
                        $time, want.pressure_pa, rsp_pressure_pa);
               error_count++;
            end
         end
      end
   end

   task automatic send_reading(input logic [RAW_W-1:0] pressure_raw,
                               input logic [RAW_W-1:0] temperature_raw);
      req_valid <= 1'b1;
      req_pressure_raw <= pressure_raw;
      req_temperature_raw <= temperature_raw;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(predict_reading(pressure_raw, temperature_raw));
   endtask

   task automatic hold_requests(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_calibration(input int index, input logic [COEF_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(index * 4);
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index < NUM_REGS) cal_word[index] = value;
      @(posedge clock);
   endtask

   task automatic load_calibration(input logic [COEF_W-1:0] sens_at_ref,
                                   input logic [COEF_W-1:0] offset_at_ref,
                                   input logic [COEF_W-1:0] sens_temp_coeff,
                                   input logic [COEF_W-1:0] offset_temp_coeff,
                                   input logic [COEF_W-1:0] ref_temperature,
                                   input logic [COEF_W-1:0] temp_sensitivity);
      drain_pipeline();
      write_calibration(REG_SENS_AT_REF, sens_at_ref);
      write_calibration(REG_OFFSET_AT_REF, offset_at_ref);
      write_calibration(REG_SENS_TEMP_COEFF, sens_temp_coeff);
      write_calibration(REG_OFFSET_TEMP_COEFF, offset_temp_coeff);
      write_calibration(REG_REF_TEMPERATURE, ref_temperature);
      write_calibration(REG_TEMP_SENSITIVITY, temp_sensitivity);
   endtask

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COEF_MAX;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_calibration();
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
   endtask

   task automatic test_typical_calibration();
      load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      send_reading(24'd9085466, 24'd8569150);
      send_reading(24'd9085466, 24'd7000000);
      send_reading('0, 24'd3000000);
      send_reading(RAW_MAX, 24'd8569150);
   endtask

   task automatic test_branch_boundaries();
      load_calibration(random_coef(), random_coef(), random_coef(), random_coef(),
                       16'd32768, 16'd8192);
      send_reading(24'd9085466, 24'd8388608);
      send_reading(24'd9085466, 24'd8388607);
      send_reading(24'd9085466, 24'd4804608);
      send_reading(24'd9085466, 24'd4804607);
      send_reading(RAW_MAX, '0);
   endtask

   task automatic test_extreme_calibration();
      load_calibration(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      load_calibration(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, '0, COEF_MAX);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
   endtask

   task automatic test_unmapped_registers();
      drain_pipeline();
      write_calibration(REG_UNMAPPED_LO, COEF_W'($urandom));
      write_calibration(REG_UNMAPPED_HI, COEF_W'($urandom));
      send_reading(24'd9085466, 24'd8569150);
      send_reading(RAW_MAX, 24'd1000000);
   endtask

   task automatic test_random_readings(input int phases, input int per_phase);
      int phase, i, burst_left, gap;
      logic [RAW_W-1:0] pressure_raw, temperature_raw;
      for (phase = 0; phase < phases; phase++) begin
         load_calibration(random_coef(), random_coef(), random_coef(), random_coef(),
                          random_coef(), random_coef());
         burst_left = 0;
         for (i = 0; i < per_phase; i++) begin
            if (phase == phases / 2 && i == per_phase / 2) begin
               drain_pipeline();
            end else if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(30, 80);
                  gap = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap = $urandom_range(0, 6);
               end
               if (gap > 0) hold_requests(gap);
            end
            pressure_raw = RAW_W'($urandom);
            temperature_raw = RAW_W'($urandom);
            case ($urandom_range(0, 5))
               0, 1: temperature_raw = RAW_W'({cal_word[REG_REF_TEMPERATURE], 8'd0} +
                                              $urandom_range(0, 1 << 18) - (1 << 17));
               2: temperature_raw = RAW_W'({cal_word[REG_REF_TEMPERATURE], 8'd0} -
                                           $urandom_range(0, 1 << 23));
               3: begin
                  pressure_raw = $urandom_range(0, 1) ? RAW_MAX : '0;
                  temperature_raw = $urandom_range(0, 1) ? RAW_MAX : '0;
               end
               default: ;
            endcase
            send_reading(pressure_raw, temperature_raw);
            burst_left--;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) cal_word[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_calibration();
      test_typical_calibration();
      test_branch_boundaries();
      test_extreme_calibration();
      test_unmapped_registers();
      test_random_readings(6, 150);
      drain_pipeline();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
